FILE: hw/rtl/lct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lct_pkg;

  localparam int SLOPE_W = 32;
  localparam int ICPT_W  = 62;
  localparam int VALUE_W = 64;
  localparam int STACK_DEPTH = 32;
  localparam int STACK_PTR_W = 6;

  localparam logic signed [VALUE_W-1:0] NO_LINE_VALUE = 64'sd2000000000000000000;

  localparam logic [1:0] ACT_INSERT_ALL = 2'd0;
  localparam logic [1:0] ACT_INSERT_SEG = 2'd1;
  localparam logic [1:0] ACT_QUERY      = 2'd2;

  localparam logic REG_DOMAIN_LOW = 1'b0;

  // one stored node: valid bit and its line
  typedef struct packed {
    logic                valid;
    logic [SLOPE_W-1:0]  slope;
    logic [ICPT_W-1:0]   intercept;
  } node_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lct_node_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module lct_node_mem #(
  parameter int ADDR_W = 17
) (
  input  wire                 clk,
  input  wire                 we,
  input  wire [ADDR_W-1:0]    waddr,
  input  lct_pkg::node_t      wdata,
  input  wire [ADDR_W-1:0]    raddr,
  output lct_pkg::node_t      rdata
);
  import lct_pkg::*;

  node_t mem [(1 << ADDR_W)];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lct_eval_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module lct_eval_unit #(
  parameter int POS_W = 16
) (
  input  wire                          clk,
  input  wire [lct_pkg::SLOPE_W-1:0]   slope,
  input  wire [lct_pkg::ICPT_W-1:0]    intercept,
  input  wire [POS_W-1:0]              pos,
  input  wire [31:0]                   domain_low,
  output logic [lct_pkg::VALUE_W-1:0]  value
);
  import lct_pkg::*;

  logic signed [32:0]        x;
  logic signed [65:0]        prod_full;
  logic signed [VALUE_W-1:0] prod;
  logic signed [VALUE_W-1:0] icpt_q;

  // x = domain_low + pos, 33 bits signed
  always_comb begin
    x = $signed({domain_low[31], domain_low})
      + $signed({{(33-POS_W){1'b0}}, pos});
    prod_full = $signed({{34{slope[SLOPE_W-1]}}, slope}) * $signed({{33{x[32]}}, x});
  end

  // stage one: product, stage two: add intercept
  always_ff @(posedge clk) begin
    prod   <= prod_full[VALUE_W-1:0];
    icpt_q <= $signed({{(VALUE_W-ICPT_W){intercept[ICPT_W-1]}}, intercept});
    value  <= prod + icpt_q;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/li_chao_min_line_tree.sv
`timescale 1ns / 1ps
`default_nettype none
// li chao tree, minimum of stored lines; one item at a time, busy high while it works
// query: for each tree level, read, check, multiply-add in the shared evaluation unit
//   for a valid node, then step
// whole-domain insert: up to 17 levels, each with read, check, four evaluations, decide
// segment insert: a pop and a check per visited node plus a descent for each covering node
// reset: synchronous; a clearing pass writes all 2^(DOMAIN_BITS+1) nodes invalid
// results are a one-cycle done strobe; the receiver cannot stall
module li_chao_min_line_tree #(
  parameter int DOMAIN_BITS = 16
) (
  input  wire         clk,
  input  wire         rst,
  // item channel
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  action,
  input  wire  [31:0] slope,
  input  wire  [61:0] intercept,
  input  wire  [15:0] seg_low,
  input  wire  [15:0] seg_high,
  input  wire  [15:0] point,
  // result channel
  output logic        done,
  output logic [63:0] min_value,
  output logic        has_line,
  // configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lct_pkg::*;

  localparam int POS_W = DOMAIN_BITS;
  localparam int IDX_W = DOMAIN_BITS + 1;
  localparam logic [31:0] LAST32 = 32'((64'd1 << DOMAIN_BITS) - 64'd1);
  localparam logic [POS_W-1:0] LAST = {POS_W{1'b1}};

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_DRD   = 13'b0000000000100,
    S_DCHK  = 13'b0000000001000,
    S_EV1   = 13'b0000000010000,
    S_EV2   = 13'b0000000100000,
    S_EV3   = 13'b0000001000000,
    S_DDEC  = 13'b0000010000000,
    S_QRD   = 13'b0000100000000,
    S_QCHK  = 13'b0001000000000,
    S_QSTEP = 13'b0010000000000,
    S_SPOP  = 13'b0100000000000,
    S_SCHK  = 13'b1000000000000
  } state_t;

  state_t state;

  // configuration register
  logic [31:0] domain_low;

  // item context
  logic             qmode;      // evaluating for a query
  logic             ret_seg;    // descent belongs to a segment insert
  logic [SLOPE_W-1:0] cur_k;    // line being pushed down
  logic [ICPT_W-1:0]  cur_b;
  logic [SLOPE_W-1:0] line_k;   // line of the item, restarts each covering node
  logic [ICPT_W-1:0]  line_b;
  logic [15:0]      seg_a;
  logic [15:0]      seg_z;
  logic [POS_W-1:0] qpos;
  logic [IDX_W-1:0] idx;
  logic [POS_W-1:0] lo;
  logic [POS_W-1:0] hi;
  logic [POS_W-1:0] mid;
  logic [1:0]       ev_sel;
  logic [VALUE_W-1:0] ev_val [4];
  logic signed [VALUE_W-1:0] best;
  logic             found;

  // segment work stack
  logic [IDX_W-1:0]       stack [STACK_DEPTH];
  logic [STACK_PTR_W-1:0] top;
  logic [STACK_PTR_W-1:0] top_m1;
  logic [IDX_W-1:0]       pop_idx;
  logic [POS_W-1:0]       pop_lo;
  logic [POS_W-1:0]       pop_hi;

  // clearing pass
  logic [IDX_W:0] clr_cnt;

  // node memory
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  node_t            mem_wdata;
  node_t            rd;

  // shared evaluation unit
  logic [SLOPE_W-1:0] ev_k;
  logic [ICPT_W-1:0]  ev_b;
  logic [POS_W-1:0]   ev_pos;
  logic [VALUE_W-1:0] ev_out;

  logic [31:0] lo32;
  logic [31:0] hi32;
  logic        win_l;
  logic        win_m;

  // range [lo,hi] of a node index
  function automatic logic [2*POS_W-1:0] node_range(input logic [IDX_W-1:0] n);
    int d;
    logic [31:0] base;
    logic [31:0] span;
    logic [31:0] last;
    d = 0;
    base = 32'd0;
    for (int i = 0; i < IDX_W; i++) begin
      if (n[i]) d = i;
    end
    base = (32'(n) & ~(32'd1 << d)) << (DOMAIN_BITS - d);
    span = (32'd1 << (DOMAIN_BITS - d)) - 32'd1;
    last = base + span;
    return {base[POS_W-1:0], last[POS_W-1:0]};
  endfunction

  assign mid    = lo + ((hi - lo) >> 1);
  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DOMAIN_LOW) ? domain_low : 32'd0;
  assign top_m1 = top - 6'd1;
  assign pop_idx = stack[top_m1[4:0]];
  assign {pop_lo, pop_hi} = node_range(pop_idx);
  assign lo32 = {{(32-POS_W){1'b0}}, lo};
  assign hi32 = {{(32-POS_W){1'b0}}, hi};
  assign win_l = $signed(ev_val[0]) < $signed(ev_val[1]);
  assign win_m = $signed(ev_val[2]) < $signed(ev_val[3]);

  // evaluation operands: for inserts, even steps use the new line, odd the stored one;
  // the first two evaluate at lo, the last two at the midpoint
  always_comb begin
    if (qmode) begin
      ev_k   = rd.slope;
      ev_b   = rd.intercept;
      ev_pos = qpos;
    end else begin
      ev_k   = ev_sel[0] ? rd.slope : cur_k;
      ev_b   = ev_sel[0] ? rd.intercept : cur_b;
      ev_pos = ev_sel[1] ? mid : lo;
    end
  end

  // memory write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = '{valid: 1'b1, slope: cur_k, intercept: cur_b};
    unique case (state)
      S_CLEAR: begin
        mem_we          = 1'b1;
        mem_waddr       = clr_cnt[IDX_W-1:0];
        mem_wdata.valid = 1'b0;
      end
      S_DCHK: mem_we = !rd.valid;
      S_DDEC: mem_we = win_m;
      default: mem_we = 1'b0;
    endcase
  end

  lct_node_mem #(.ADDR_W(IDX_W)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx),
    .rdata (rd)
  );

  lct_eval_unit #(.POS_W(POS_W)) u_eval (
    .clk        (clk),
    .slope      (ev_k),
    .intercept  (ev_b),
    .pos        (ev_pos),
    .domain_low (domain_low),
    .value      (ev_out)
  );

  // configuration write
  always_ff @(posedge clk) begin
    if (rst) begin
      domain_low <= 32'd0;
    end else if (psel && penable && pwrite && paddr[2] == REG_DOMAIN_LOW) begin
      domain_low <= pwdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
      top     <= '0;
      qmode   <= 1'b0;
      ret_seg <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt[IDX_W-1:0] == {IDX_W{1'b1}}) state <= S_IDLE;
        end
        S_IDLE: begin
          cur_k  <= slope;
          cur_b  <= intercept;
          line_k <= slope;
          line_b <= intercept;
          seg_a  <= seg_low;
          seg_z  <= seg_high;
          qpos   <= POS_W'(point);
          idx    <= IDX_W'(1);
          lo     <= '0;
          hi     <= LAST;
          best   <= NO_LINE_VALUE;
          found  <= 1'b0;
          if (start) begin
            case (action)
              ACT_INSERT_ALL: begin
                qmode   <= 1'b0;
                ret_seg <= 1'b0;
                state   <= S_DRD;
              end
              ACT_INSERT_SEG: begin
                qmode   <= 1'b0;
                ret_seg <= 1'b1;
                // empty segment or one past the domain does nothing
                if (seg_low <= seg_high && {16'd0, seg_low} <= LAST32) begin
                  stack[0] <= IDX_W'(1);
                  top      <= 6'd1;
                  state    <= S_SPOP;
                end
              end
              ACT_QUERY: begin
                qmode <= 1'b1;
                if ({16'd0, point} <= LAST32) begin
                  state <= S_QRD;
                end else begin
                  done      <= 1'b1;
                  min_value <= NO_LINE_VALUE;
                  has_line  <= 1'b0;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        // descent of an insert
        S_DRD: state <= S_DCHK;
        S_DCHK: begin
          ev_sel <= 2'd0;
          if (!rd.valid) begin
            state <= ret_seg ? S_SPOP : S_IDLE;
          end else begin
            state <= S_EV1;
          end
        end
        S_EV1: state <= S_EV2;
        S_EV2: state <= S_EV3;
        S_EV3: begin
          if (qmode) begin
            if (!found || $signed(ev_out) < best) best <= $signed(ev_out);
            found <= 1'b1;
            state <= S_QSTEP;
          end else begin
            ev_val[ev_sel] <= ev_out;
            ev_sel         <= ev_sel + 2'd1;
            state          <= (ev_sel == 2'd3) ? S_DDEC : S_EV1;
          end
        end
        S_DDEC: begin
          // new line wins the midpoint: it stays here, the old one moves on
          if (win_m) begin
            cur_k <= rd.slope;
            cur_b <= rd.intercept;
          end
          if (lo == hi) begin
            state <= ret_seg ? S_SPOP : S_IDLE;
          end else begin
            if (win_l != win_m) begin
              idx <= {idx[IDX_W-2:0], 1'b0};
              hi  <= mid;
            end else begin
              idx <= {idx[IDX_W-2:0], 1'b1};
              lo  <= mid + 1'b1;
            end
            state <= S_DRD;
          end
        end
        // query walk
        S_QRD: state <= S_QCHK;
        S_QCHK: state <= rd.valid ? S_EV1 : S_QSTEP;
        S_QSTEP: begin
          if (lo == hi) begin
            done      <= 1'b1;
            min_value <= best;
            has_line  <= found;
            state     <= S_IDLE;
          end else begin
            if (qpos <= mid) begin
              idx <= {idx[IDX_W-2:0], 1'b0};
              hi  <= mid;
            end else begin
              idx <= {idx[IDX_W-2:0], 1'b1};
              lo  <= mid + 1'b1;
            end
            state <= S_QRD;
          end
        end
        // segment decomposition
        S_SPOP: begin
          if (top == '0) begin
            state <= S_IDLE;
          end else begin
            idx   <= pop_idx;
            lo    <= pop_lo;
            hi    <= pop_hi;
            top   <= top_m1;
            state <= S_SCHK;
          end
        end
        S_SCHK: begin
          if (hi32 < {16'd0, seg_a} || lo32 > {16'd0, seg_z}) begin
            state <= S_SPOP;
          end else if ({16'd0, seg_a} <= lo32 && hi32 <= {16'd0, seg_z}) begin
            // every covering node starts from the item's own line
            cur_k <= line_k;
            cur_b <= line_b;
            state <= S_DRD;
          end else if (lo == hi || top > 6'(STACK_DEPTH - 2)) begin
            state <= S_SPOP;
          end else begin
            stack[top[4:0]]           <= {idx[IDX_W-2:0], 1'b1};
            stack[5'(top[4:0] + 5'd1)] <= {idx[IDX_W-2:0], 1'b0};
            top                       <= top + 6'd2;
            state                     <= S_SPOP;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // an empty query result always carries the no-line value
  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    done && !has_line |-> min_value == NO_LINE_VALUE)
    else $error("empty result without no-line value");

  // work stack never passes its depth
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    top <= 6'(STACK_DEPTH))
    else $error("segment stack overflow");

  // a result only comes from the query walk or an out-of-domain query
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_QSTEP || $past(state) == S_IDLE)
    else $error("result outside query path");

  // an accepted whole-domain insert starts a memory read
  a_insert_starts: assert property (@(posedge clk) disable iff (rst)
    start && !busy && action == ACT_INSERT_ALL |=> state == S_DRD)
    else $error("insert did not start descent");
`endif

endmodule
`default_nettype wire

FILE: verif/tb_li_chao_min_line_tree.sv
`timescale 1ns / 1ps
module tb_li_chao_min_line_tree;
  import lct_pkg::*;

  localparam int DBITS = 16;
  localparam int unsigned LEAF_LAST = (1 << DBITS) - 1;
  localparam int unsigned NODES = 1 << (DBITS + 1);
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // answer of one query
  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               covered;
  } query_answer_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  action;
  logic [31:0] slope;
  logic [61:0] intercept;
  logic [15:0] seg_low;
  logic [15:0] seg_high;
  logic [15:0] point;
  logic        done;
  logic [63:0] min_value;
  logic        has_line;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  li_chao_min_line_tree #(.DOMAIN_BITS(DBITS)) u_dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy), .action(action), .slope(slope), .intercept(intercept),
    .seg_low(seg_low), .seg_high(seg_high), .point(point),
    .done(done), .min_value(min_value), .has_line(has_line),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow copy of the tree, sparse since only a few nodes get written
  bit     tree_valid[int unsigned];
  longint tree_slope[int unsigned];
  longint tree_icpt[int unsigned];
  longint shadow_domain_low;

  query_answer_t pending_answers[$];
  int unsigned   fail_count;
  bit            allow_gaps;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop, well beyond the reset clearing pass plus the slowest item mix
  initial begin
    #200ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint eval_line(longint k, longint b, int unsigned pos);
    return k * (shadow_domain_low + longint'(pos)) + b;
  endfunction

  // walk down from idx, keeping the lower line at each midpoint
  function automatic void push_line_down(int unsigned idx, int unsigned l, int unsigned r,
                                         longint k, longint b);
    int unsigned m;
    bit win_l;
    bit win_m;
    longint tk;
    longint tb;
    while (idx < NODES) begin
      if (!tree_valid.exists(idx)) begin
        tree_valid[idx] = 1'b1;
        tree_slope[idx] = k;
        tree_icpt[idx]  = b;
        return;
      end
      m = (l + r) / 2;
      win_l = eval_line(k, b, l) < eval_line(tree_slope[idx], tree_icpt[idx], l);
      win_m = eval_line(k, b, m) < eval_line(tree_slope[idx], tree_icpt[idx], m);
      if (win_m) begin
        tk = tree_slope[idx];
        tb = tree_icpt[idx];
        tree_slope[idx] = k;
        tree_icpt[idx]  = b;
        k = tk;
        b = tb;
      end
      if (l == r) return;
      if (win_l != win_m) begin
        idx = 2 * idx;
        r = m;
      end else begin
        idx = 2 * idx + 1;
        l = m + 1;
      end
    end
  endfunction

  // split the segment into covering nodes, depth-first, left child first
  function automatic void insert_on_segment(int unsigned a, int unsigned z,
                                            longint k, longint b);
    int unsigned work[$];
    int unsigned idx;
    int unsigned depth;
    int unsigned l;
    int unsigned r;
    if (a > z || a > LEAF_LAST) return;
    work.push_back(1);
    while (work.size() > 0) begin
      idx = work.pop_back();
      depth = $clog2(idx + 1) - 1;
      l = (idx - (1 << depth)) << (DBITS - depth);
      r = l + ((1 << (DBITS - depth)) - 1);
      if (r < a || l > z) continue;
      if (a <= l && r <= z) begin
        push_line_down(idx, l, r, k, b);
        continue;
      end
      if (l == r || 2 * idx + 1 >= NODES || work.size() + 2 > STACK_DEPTH) continue;
      work.push_back(2 * idx + 1);
      work.push_back(2 * idx);
    end
  endfunction

  function automatic query_answer_t lowest_at(int unsigned p);
    query_answer_t ans;
    int unsigned idx;
    int unsigned l;
    int unsigned r;
    int unsigned m;
    longint v;
    longint best;
    best = NO_LINE_VALUE;
    ans.covered = 1'b0;
    idx = 1;
    l = 0;
    r = LEAF_LAST;
    if (p <= LEAF_LAST) begin
      while (idx < NODES) begin
        if (tree_valid.exists(idx)) begin
          v = eval_line(tree_slope[idx], tree_icpt[idx], p);
          if (!ans.covered || v < best) best = v;
          ans.covered = 1'b1;
        end
        if (l == r) break;
        m = (l + r) / 2;
        if (p <= m) begin
          idx = 2 * idx;
          r = m;
        end else begin
          idx = 2 * idx + 1;
          l = m + 1;
        end
      end
    end
    ans.value = best;
    return ans;
  endfunction

  // ------------------------------------------------------------- result check

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual min_value=%0d has_line=%0b",
                 $realtime, $signed(min_value), has_line);
        fail_count++;
      end else begin
        if (min_value !== pending_answers[0].value) begin
          $display("%0t: min_value mismatch, expected %0d, actual %0d", $realtime,
                   $signed(pending_answers[0].value), $signed(min_value));
          fail_count++;
        end
        if (has_line !== pending_answers[0].covered) begin
          $display("%0t: has_line mismatch, expected %0b, actual %0b", $realtime,
                   pending_answers[0].covered, has_line);
          fail_count++;
        end
        void'(pending_answers.pop_front());
      end
    end
  end

  // ------------------------------------------------------------------ drivers

  // hand one item to the block, then update the shadow tree or queue the expected answer on acceptance
  task automatic send_item(logic [1:0] act, logic [31:0] k, logic [61:0] b,
                           logic [15:0] a, logic [15:0] z, logic [15:0] p);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    start = 1'b1;
    action = act;
    slope = k;
    intercept = b;
    seg_low = a;
    seg_high = z;
    point = p;
    do @(posedge clk); while (busy);
    case (act)
      ACT_INSERT_ALL: push_line_down(1, 0, LEAF_LAST, $signed(k), $signed(b));
      ACT_INSERT_SEG: insert_on_segment(a, z, $signed(k), $signed(b));
      ACT_QUERY: pending_answers.push_back(lowest_at(p));
      default: ;
    endcase
    @(negedge clk);
    start = 1'b0;
    action = 2'($urandom());
    point = 16'($urandom());
  endtask

  // wait until every answer is in and the block has finished any trailing insert
  task automatic drain();
    while (pending_answers.size() > 0 || busy) @(negedge clk);
    repeat (150) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_domain_low(logic signed [31:0] x);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = 3'(REG_DOMAIN_LOW) << 2;
    pwdata = x;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== x) begin
      $display("%0t: domain_low readback mismatch, expected %0d, actual %0d",
               $realtime, x, $signed(prdata));
      fail_count++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    shadow_domain_low = longint'(x);
  endtask

  function automatic logic [61:0] rand_icpt();
    return 62'({$urandom(), $urandom()});
  endfunction

  // -------------------------------------------------------------------- tests

  // empty tree, extreme lines, degenerate and full segments, unused action
  task automatic test_directed();
    send_item(ACT_QUERY, '0, '0, '0, '0, 16'd0);
    send_item(ACT_QUERY, '0, '0, '0, '0, 16'hffff);
    // empty segment must leave the tree untouched
    send_item(ACT_INSERT_SEG, 32'd5, 62'd9, 16'd100, 16'd99, '0);
    send_item(ACT_UNUSED, 32'd1, 62'd1, 16'd0, 16'hffff, 16'd3);
    send_item(ACT_QUERY, '0, '0, '0, '0, 16'd100);
    send_item(ACT_INSERT_SEG, 32'sd3, 62'sd7, 16'd200, 16'd200, '0);
    send_item(ACT_QUERY, '0, '0, '0, '0, 16'd200);
    send_item(ACT_QUERY, '0, '0, '0, '0, 16'd201);
    send_item(ACT_INSERT_ALL, 32'h7fffffff, 62'h1fffffffffffffff, '0, '0, '0);
    send_item(ACT_INSERT_ALL, 32'h80000000, 62'h2000000000000000, '0, '0, '0);
    send_item(ACT_INSERT_ALL, 32'h80000000, 62'h1fffffffffffffff, '0, '0, '0);
    // equal line must not displace the stored one
    send_item(ACT_INSERT_ALL, 32'h7fffffff, 62'h1fffffffffffffff, '0, '0, '0);
    send_item(ACT_INSERT_SEG, 32'h7fffffff, 62'h2000000000000000, 16'd0, 16'hffff, '0);
    send_item(ACT_INSERT_SEG, 32'sd0, -62'sd1, 16'd1, 16'hfffe, '0);
    send_item(ACT_INSERT_SEG, 32'sd0, -62'sd2, 16'hffff, 16'hffff, '0);
    send_item(ACT_QUERY, '0, '0, '0, '0, 16'd0);
    send_item(ACT_QUERY, '0, '0, '0, '0, 16'd1);
    send_item(ACT_QUERY, '0, '0, '0, '0, 16'h7fff);
    send_item(ACT_QUERY, '0, '0, '0, '0, 16'h8000);
    send_item(ACT_QUERY, '0, '0, '0, '0, 16'hfffe);
    send_item(ACT_QUERY, '0, '0, '0, '0, 16'hffff);
  endtask

  // mostly segments and queries with random content, a few whole-domain inserts and unused actions
  task automatic test_random_mix(int n);
    int pick;
    logic [15:0] a;
    logic [15:0] z;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      a = 16'($urandom());
      z = 16'($urandom());
      if ($urandom_range(0, 3) != 0 && a > z) {a, z} = {z, a};
      if ($urandom_range(0, 2) == 0) z = a + 16'($urandom_range(0, 63));
      if (pick < 15)
        send_item(ACT_INSERT_ALL, $urandom(), rand_icpt(), a, z, 16'($urandom()));
      else if (pick < 50)
        send_item(ACT_INSERT_SEG, $urandom(), rand_icpt(), a, z, 16'($urandom()));
      else if (pick < 95)
        send_item(ACT_QUERY, $urandom(), rand_icpt(), a, z,
                  ($urandom_range(0, 1) == 0) ? a + 16'($urandom_range(0, 63))
                                              : 16'($urandom()));
      else
        send_item(ACT_UNUSED, $urandom(), rand_icpt(), a, z, 16'($urandom()));
    end
  endtask

  task automatic test_domain_settings();
    logic signed [31:0] settings[4];
    settings[0] = -32'sd1073741824;
    settings[1] = 32'sd1073741824;
    settings[2] = $urandom_range(0, 32'h7fffffff) - 32'sd1073741824;
    settings[3] = 32'sd0;
    foreach (settings[i]) begin
      drain();
      write_domain_low(settings[i]);
      test_random_mix(170);
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    action = '0;
    slope = '0;
    intercept = '0;
    seg_low = '0;
    seg_high = '0;
    point = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_count = 0;
    shadow_domain_low = 0;
    allow_gaps = 1'b1;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random_mix(100);
    test_domain_settings();
    // closing stretch back to back
    allow_gaps = 1'b0;
    test_random_mix(60);

    drain();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/lct_pkg.sv
hw/rtl/lct_node_mem.sv
hw/rtl/lct_eval_unit.sv
hw/rtl/li_chao_min_line_tree.sv
verif/tb_li_chao_min_line_tree.sv
